// ===== sv/assert_macros.svh =====
// Assertion macros used by the store's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== sv/sdms_pkg.sv =====
// Package: types, constants and score function of the message store.
package sdms_pkg;
    localparam int StoreDepth = 256;
    localparam int IdxW = $clog2(StoreDepth);
    localparam int CntW = IdxW + 1;
    localparam int ScoreW = 24;

    typedef enum logic [2:0] {
        OUT_FILTERED  = 3'd0,
        OUT_DUPLICATE = 3'd1,
        OUT_APPENDED  = 3'd2,
        OUT_REPLACED  = 3'd3,
        OUT_REJECTED  = 3'd4
    } t_outcome;

    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_MIN_DIFF = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  difficulty;
        logic [15:0] created;
        logic [15:0] size;
    } t_entry;

    // token type: a valid flag, a store index and an entry
    typedef struct packed {
        logic              valid;
        logic [IdxW-1:0]   idx;
        t_entry            ent;
    } t_tok;

    // score*16 = d*16000 - age*16 - size
    function automatic logic signed [ScoreW-1:0] score16(
        input logic [7:0] d, input logic [15:0] c, input logic [15:0] s,
        input logic [15:0] today);
        logic [15:0] age;
        logic signed [ScoreW-1:0] r;
        begin
            age = (today > c) ? (today - c) : 16'd0;
            r = $signed({2'b0, d * 22'd16000}) - $signed({4'b0, age, 4'b0})
                - $signed({8'b0, s});
            return r;
        end
    endfunction
endpackage

// ===== sv/sdms_if.sv =====
// Valid/ready channel interfaces of the message store.
interface sdms_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_id;
    logic [7:0]  difficulty;
    logic [15:0] created_on;
    logic [15:0] expires_on;
    logic [15:0] byte_size;
    logic [15:0] current_day;
    logic        relayed;
    modport source (output valid, message_id, difficulty, created_on, expires_on,
                    byte_size, current_day, relayed, input ready);
    modport sink (input valid, message_id, difficulty, created_on, expires_on,
                  byte_size, current_day, relayed, output ready);
endinterface

interface sdms_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  outcome;
    logic [7:0]  slot;
    logic [31:0] evicted_id;
    modport source (output valid, outcome, slot, evicted_id, input ready);
    modport sink (input valid, outcome, slot, evicted_id, output ready);
endinterface

interface sdms_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [8:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/sdms_cell.sv =====
// One store cell: holds an entry and takes its neighbour's entry when the ring shifts.
module sdms_cell
    import sdms_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_prev,
    output t_entry o_ent
);
    t_entry r_ent;
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_ent <= i_prev;
        end
    end
    assign o_ent = r_ent;
endmodule

// ===== sv/scored_dedup_message_store.sv =====
// Top level of the scored duplicate-free message store.
// Entries sit in a ring of cells that rotates one place per cycle while it scans or writes.
// An appended or replaced word passes the scan rotation, decide, write rotation and
// result load; a duplicate or rejected word skips the write rotation; a filtered word
// goes straight to the result load. The next word is accepted while a result waits.
// Reset (synchronous, low) empties the store and loads capacity 256, minimum
// difficulty 18.
`include "assert_macros.svh"
module scored_dedup_message_store
    import sdms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdms_in_if.sink    i_in,
    sdms_out_if.source o_out,
    sdms_cfg_if.sink   i_cfg
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_WRITE, S_OUT} t_state;

    t_state            r_state;
    logic [CntW-1:0]   r_fill, r_cap;
    logic [7:0]        r_min_diff;
    logic [CntW-1:0]   r_cnt;
    t_entry            r_new;
    logic [15:0]       r_today;
    logic              r_dup;
    logic              r_rep;
    logic [IdxW-1:0]   r_worst;
    logic [31:0]       r_worst_id;
    logic signed [ScoreW-1:0] r_worst_s;
    logic [2:0]        r_outcome;
    logic [7:0]        r_slot;
    logic [31:0]       r_evict;
    logic              r_valid;
    logic [2:0]        r_out_outcome;
    logic [7:0]        r_out_slot;
    logic [31:0]       r_out_evict;

    // ring: cell k holds entry (k + rotation) mod depth; cell 0 is the read head
    t_entry w_cell [StoreDepth];
    logic   w_shift;
    t_entry w_head_in;
    logic   w_write;

    for (genvar k = 0; k < StoreDepth; k++) begin : g_ring
        sdms_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(w_shift),
            .i_prev ((k == StoreDepth-1) ? w_head_in : w_cell[(k+1) % StoreDepth]),
            .o_ent  (w_cell[k])
        );
    end

    // the head entry leaves cell 0 and re-enters at the tail, replaced when written
    assign w_head_in = w_write ? r_new : w_cell[0];
    assign w_shift = (r_state == S_SCAN) || (r_state == S_WRITE);
    // write happens on the rotation step that carries the target past the head
    assign w_write = (r_state == S_WRITE) && (r_cnt[IdxW-1:0] == r_worst);

    logic [CntW-1:0] w_cap_eff;
    always_comb begin
        if (i_cfg.data == '0) begin
            w_cap_eff = CntW'(1);
        end else if (i_cfg.data > 9'(StoreDepth)) begin
            w_cap_eff = CntW'(StoreDepth);
        end else begin
            w_cap_eff = CntW'(i_cfg.data);
        end
    end

    logic signed [ScoreW-1:0] w_head_s, w_new_s;
    assign w_head_s = score16(w_cell[0].difficulty, w_cell[0].created, w_cell[0].size,
                              r_today);
    assign w_new_s  = score16(r_new.difficulty, r_new.created, r_new.size, r_today);
    logic w_in_fill;
    assign w_in_fill = r_cnt < r_fill;

    // result register can take a new word when empty or being read out
    logic w_out_free;
    assign w_out_free = !r_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_valid;
    assign o_out.outcome = r_out_outcome;
    assign o_out.slot = r_out_slot;
    assign o_out.evicted_id = r_out_evict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_cap <= CntW'(StoreDepth);
            r_min_diff <= 8'd18;
            r_valid <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_CAPACITY: r_cap <= w_cap_eff;
                    REG_MIN_DIFF: r_min_diff <= i_cfg.data[7:0];
                    default: ;
                endcase
            end
            if (r_state == S_OUT && w_out_free) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_new <= '{i_in.message_id, i_in.difficulty, i_in.created_on,
                                   i_in.byte_size};
                        r_today <= i_in.current_day;
                        r_dup <= 1'b0;
                        r_cnt <= '0;
                        r_slot <= '0;
                        r_evict <= '0;
                        if (i_in.relayed && (i_in.difficulty < r_min_diff
                                || i_in.expires_on < i_in.current_day)) begin
                            r_outcome <= OUT_FILTERED;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_in_fill) begin
                        if (w_cell[0].id == r_new.id) r_dup <= 1'b1;
                        if (r_cnt == '0 || w_head_s < r_worst_s) begin
                            r_worst_s <= w_head_s;
                            r_worst <= r_cnt[IdxW-1:0];
                            r_worst_id <= w_cell[0].id;
                        end
                    end
                    if (r_cnt == CntW'(StoreDepth - 1)) begin
                        r_state <= S_DECIDE;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_DECIDE: begin
                    r_cnt <= '0;
                    r_rep <= 1'b0;
                    if (r_dup) begin
                        r_outcome <= OUT_DUPLICATE;
                        r_state <= S_OUT;
                    end else if (r_fill < r_cap) begin
                        r_outcome <= OUT_APPENDED;
                        r_slot <= 8'(r_fill);
                        r_worst <= r_fill[IdxW-1:0];
                        r_fill <= r_fill + 1'b1;
                        r_state <= S_WRITE;
                    end else if (w_new_s > r_worst_s) begin
                        r_outcome <= OUT_REPLACED;
                        r_slot <= 8'(r_worst);
                        r_evict <= r_worst_id;
                        r_rep <= 1'b1;
                        r_state <= S_WRITE;
                    end else begin
                        r_outcome <= OUT_REJECTED;
                        r_state <= S_OUT;
                    end
                end
                S_WRITE: begin
                    if (r_cnt == CntW'(StoreDepth - 1)) begin
                        r_state <= S_OUT;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_outcome <= r_outcome;
                        r_out_slot <= r_slot;
                        r_out_evict <= r_evict;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_fill_bound, i_clk, i_rst_n, r_fill <= CntW'(StoreDepth), "fill over depth")
    `ASSERT_CLK(a_no_accept_busy, i_clk, i_rst_n, (r_state != S_IDLE) |-> !i_in.ready, "busy accept")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (r_valid && !o_out.ready) |=> r_valid, "result dropped")
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, (r_valid && !o_out.ready) |=> $stable(r_out_outcome), "result changed")
    `ASSERT_CLK(a_rep_full, i_clk, i_rst_n, (r_state == S_WRITE && r_rep) |-> r_fill != '0, "replace empty")
endmodule
